>>> hdl/pba_pkg.sv
// Shared types and constants of the paged bump allocator.
package pba_pkg;

    // Field widths fixed by the item format
    localparam int ACTION_W     = 2;
    localparam int ALIGN_W      = 4;
    localparam int STATUS_W     = 3;
    localparam int PAGE_OUT_W   = 4;
    localparam int OFFSET_W     = 21;
    localparam int TOT_W        = 25;
    localparam int COUNT_OUT_W  = 5;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 21;

    // Result payload: 130 bits of fields, padded to whole bytes
    localparam int OUT_FIELDS_W = 130;
    localparam int OUT_TDATA_W  = 136;

    // Request kinds
    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RESET = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ROLL  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ALIGN  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SPACE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MARKER = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_PAGE_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ARENA_ALIGN_LOG2  = 1'd1;

    // Configuration limits and reset values
    localparam logic [CFG_DATA_W-1:0] DEFAULT_SIZE_MAX   = 21'd1048576;
    localparam logic [CFG_DATA_W-1:0] DEFAULT_SIZE_RESET = 21'd4096;
    localparam logic [ALIGN_W-1:0]    ALIGN_LOG2_MAX     = 4'd12;
    localparam logic [ALIGN_W-1:0]    ALIGN_LOG2_RESET   = 4'd4;
    // Page 0 capacity after reset: reset default aligned to the reset alignment
    localparam int RESET_PAGE_CAP = 4096;

    // Page table read address select
    localparam logic [1:0] RD_ACTIVE = 2'd0;
    localparam logic [1:0] RD_NEXT   = 2'd1;
    localparam logic [1:0] RD_MARKER = 2'd2;
    localparam logic [1:0] RD_WALK   = 2'd3;

    typedef struct packed {
        logic                load;
        logic                init;
        logic [1:0]          rd_sel;
        logic                set_status;
        logic [STATUS_W-1:0] status_code;
        logic                advance;
        logic                alloc_commit;
        logic                alloc_open;
        logic                arena_clear;
        logic                clear_write;
        logic                roll_commit;
        logic                walk_clear;
    } pba_cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                zero_size;
        logic                align_bad;
        logic                fit;
        logic                second;
        logic                next_exists;
        logic                table_full;
        logic                marker_in_range;
        logic                marker_fits;
        logic                walk_more;
    } pba_status_t;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] pages_open;
        logic [TOT_W-1:0]       capacity_total;
        logic [TOT_W-1:0]       peak_total;
        logic [TOT_W-1:0]       used_total;
        logic [OFFSET_W-1:0]    current_marker_offset;
        logic [PAGE_OUT_W-1:0]  current_marker_page;
        logic [OFFSET_W-1:0]    alloc_offset;
        logic [PAGE_OUT_W-1:0]  alloc_page;
        logic [STATUS_W-1:0]    status;
    } pba_result_t;

endpackage

>>> hdl/pba_ctrl.sv
// Sequencing state machine of the paged bump allocator.
module pba_ctrl
    import pba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        out_free,
    input  pba_status_t st,
    output pba_cmd_t    cmd,
    output logic        result_load
);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_ACHK   = 4'd3;
    localparam logic [3:0] S_RCHK   = 4'd4;
    localparam logic [3:0] S_RRD    = 4'd5;
    localparam logic [3:0] S_RCLR   = 4'd6;
    localparam logic [3:0] S_CLR    = 4'd7;
    localparam logic [3:0] S_FINISH = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd         = '0;
        cmd.rd_sel  = RD_ACTIVE;
        in_ready    = 1'b0;
        result_load = 1'b0;
        state_next  = state_reg;
        case (state_reg)
            S_INIT:
            begin
                // seed page 0 before the first item
                cmd.init   = 1'b1;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (st.action)
                    ACT_ALLOC:
                    begin
                        if (st.zero_size)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_ZERO;
                            state_next      = S_FINISH;
                        end
                        else if (st.align_bad)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_ALIGN;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            cmd.rd_sel = RD_ACTIVE;
                            state_next = S_ACHK;
                        end
                    end
                    ACT_RESET:
                    begin
                        cmd.arena_clear = 1'b1;
                        state_next      = S_CLR;
                    end
                    ACT_ROLL:
                    begin
                        if (!st.marker_in_range)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_MARKER;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            cmd.rd_sel = RD_MARKER;
                            state_next = S_RCHK;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_ACHK:
            begin
                state_next = S_FINISH;
                if (st.fit)
                begin
                    cmd.alloc_commit = 1'b1;
                end
                else if (st.second || st.next_exists == 1'b0 && st.table_full)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_SPACE;
                end
                else if (st.next_exists)
                begin
                    cmd.advance = 1'b1;
                    cmd.rd_sel  = RD_NEXT;
                    state_next  = S_ACHK;
                end
                else
                begin
                    cmd.alloc_open = 1'b1;
                end
            end
            S_RCHK:
            begin
                if (st.marker_fits)
                begin
                    cmd.roll_commit = 1'b1;
                    state_next      = S_RRD;
                end
                else
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_MARKER;
                    state_next      = S_FINISH;
                end
            end
            S_RRD:
            begin
                if (st.walk_more)
                begin
                    cmd.rd_sel = RD_WALK;
                    state_next = S_RCLR;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_RCLR:
            begin
                cmd.walk_clear = 1'b1;
                state_next     = S_RRD;
            end
            S_CLR:
            begin
                if (st.walk_more)
                begin
                    cmd.clear_write = 1'b1;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    result_load = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/pba_datapath.sv
// Page table, totals, configuration registers and allocation arithmetic.
module pba_datapath
    import pba_pkg::*;
#(
    parameter int MAX_PAGES = 16,
    parameter int SIZE_BITS = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [ACTION_W-1:0]   in_action,
    input  logic [SIZE_BITS-1:0]  in_size,
    input  logic [ALIGN_W-1:0]    in_align,
    input  logic [3:0]            in_mpage,
    input  logic [OFFSET_W-1:0]   in_moff,
    input  pba_cmd_t              cmd,
    output pba_status_t           st,
    output pba_result_t           res
);

    localparam int IDX_W  = $clog2(MAX_PAGES);
    localparam int CNT_W  = $clog2(MAX_PAGES + 1);
    localparam int PAGE_W = ((SIZE_BITS > 20) ? SIZE_BITS : 20) + 1;
    localparam int AW     = PAGE_W + 1;
    localparam int SUMW   = AW + 1;
    localparam int MW     = (CNT_W > 4) ? CNT_W : 4;

    function automatic logic [AW-1:0] align_up(input logic [AW-1:0] x,
                                               input logic [ALIGN_W-1:0] lg);
        logic [AW-1:0] m;
        m = (AW'(1) << lg) - AW'(1);
        return (x + m) & ~m;
    endfunction

    // page table
    logic [PAGE_W-1:0] cap_mem  [MAX_PAGES];
    logic [PAGE_W-1:0] fill_mem [MAX_PAGES];
    logic [PAGE_W-1:0] peak_mem [MAX_PAGES];
    logic [PAGE_W-1:0] cap_rd_reg, fill_rd_reg, peak_rd_reg;
    logic [IDX_W-1:0]  rd_addr, wr_addr;
    logic              we_cap, we_fill, we_peak;
    logic [PAGE_W-1:0] wd_cap, wd_fill, wd_peak;

    logic [CNT_W-1:0]  open_reg, walk_reg;
    logic [IDX_W-1:0]  active_reg, tgt_reg, grant_page_reg;
    logic [PAGE_W-1:0] active_fill_reg, base_reg, grant_off_reg, def_al_reg;
    logic [AW-1:0]     start_reg;
    logic              second_reg;
    logic [TOT_W-1:0]  used_reg, peak_tot_reg, cap_tot_reg;
    logic [TOT_W-1:0]  used_next, peak_tot_next, cap_tot_next;
    logic [CFG_DATA_W-1:0] default_reg;
    logic [ALIGN_W-1:0]    arena_reg;

    logic [ACTION_W-1:0]  action_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic [ALIGN_W-1:0]   alg_reg;
    logic [3:0]           mpage_reg;
    logic [OFFSET_W-1:0]  moff_reg;
    logic [STATUS_W-1:0]  status_reg;

    logic [SUMW-1:0]   sum;
    logic              fit, peak_up;
    logic [AW-1:0]     need, need_max;
    logic [PAGE_W-1:0] cap_new;
    logic [IDX_W-1:0]  new_idx, next_idx, mpage_idx, walk_idx;
    logic [MW-1:0]     mpage_w;

    assign sum       = SUMW'(start_reg) + SUMW'(size_reg);
    assign fit       = sum <= SUMW'(cap_rd_reg);
    assign peak_up   = sum > SUMW'(peak_rd_reg);
    assign need      = AW'(size_reg) + (AW'(1) << alg_reg);
    assign need_max  = (need > AW'(def_al_reg)) ? need : AW'(def_al_reg);
    assign cap_new   = PAGE_W'(align_up(need_max, arena_reg));
    assign new_idx   = IDX_W'(open_reg);
    assign next_idx  = active_reg + IDX_W'(1);
    assign mpage_w   = MW'(mpage_reg);
    assign mpage_idx = IDX_W'(mpage_w);
    assign walk_idx  = IDX_W'(walk_reg);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_ACTIVE: rd_addr = active_reg;
            RD_NEXT:   rd_addr = next_idx;
            RD_MARKER: rd_addr = mpage_idx;
            RD_WALK:   rd_addr = walk_idx;
            default:   rd_addr = active_reg;
        endcase
    end

    always_comb
    begin
        we_cap  = 1'b0;
        we_fill = 1'b0;
        we_peak = 1'b0;
        wr_addr = tgt_reg;
        wd_cap  = cap_new;
        wd_fill = '0;
        wd_peak = PAGE_W'(sum);
        if (cmd.init)
        begin
            we_cap  = 1'b1;
            we_fill = 1'b1;
            we_peak = 1'b1;
            wr_addr = '0;
            wd_cap  = PAGE_W'(RESET_PAGE_CAP);
            wd_peak = '0;
        end
        else if (cmd.alloc_commit)
        begin
            we_fill = 1'b1;
            we_peak = peak_up;
            wd_fill = PAGE_W'(sum);
        end
        else if (cmd.alloc_open)
        begin
            we_cap  = 1'b1;
            we_fill = 1'b1;
            we_peak = 1'b1;
            wr_addr = new_idx;
            wd_fill = PAGE_W'(size_reg);
            wd_peak = PAGE_W'(size_reg);
        end
        else if (cmd.roll_commit)
        begin
            we_fill = 1'b1;
            wr_addr = mpage_idx;
            wd_fill = PAGE_W'(moff_reg);
        end
        else if (cmd.clear_write || cmd.walk_clear)
        begin
            we_fill = 1'b1;
            wr_addr = walk_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_cap)
        begin
            cap_mem[wr_addr] <= wd_cap;
        end
        if (we_fill)
        begin
            fill_mem[wr_addr] <= wd_fill;
        end
        if (we_peak)
        begin
            peak_mem[wr_addr] <= wd_peak;
        end
        cap_rd_reg  <= cap_mem[rd_addr];
        fill_rd_reg <= fill_mem[rd_addr];
        peak_rd_reg <= peak_mem[rd_addr];
    end

    always_comb
    begin
        used_next     = used_reg;
        peak_tot_next = peak_tot_reg;
        cap_tot_next  = cap_tot_reg;
        if (cmd.alloc_commit)
        begin
            used_next = used_reg + TOT_W'(sum) - TOT_W'(base_reg);
            if (peak_up)
            begin
                peak_tot_next = peak_tot_reg + TOT_W'(sum) - TOT_W'(peak_rd_reg);
            end
        end
        else if (cmd.alloc_open)
        begin
            used_next     = used_reg + TOT_W'(size_reg);
            peak_tot_next = peak_tot_reg + TOT_W'(size_reg);
            cap_tot_next  = cap_tot_reg + TOT_W'(cap_new);
        end
        else if (cmd.arena_clear)
        begin
            used_next = '0;
        end
        else if (cmd.roll_commit)
        begin
            used_next = used_reg + TOT_W'(moff_reg) - TOT_W'(fill_rd_reg);
        end
        else if (cmd.walk_clear)
        begin
            used_next = used_reg - TOT_W'(fill_rd_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg        <= CNT_W'(1);
            active_reg      <= '0;
            active_fill_reg <= '0;
            used_reg        <= '0;
            peak_tot_reg    <= '0;
            cap_tot_reg     <= TOT_W'(RESET_PAGE_CAP);
            default_reg     <= DEFAULT_SIZE_RESET;
            arena_reg       <= ALIGN_LOG2_RESET;
            def_al_reg      <= PAGE_W'(RESET_PAGE_CAP);
            second_reg      <= 1'b0;
        end
        else
        begin
            used_reg     <= used_next;
            peak_tot_reg <= peak_tot_next;
            cap_tot_reg  <= cap_tot_next;
            def_al_reg   <= PAGE_W'(align_up(AW'(default_reg), arena_reg));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEFAULT_PAGE_SIZE:
                    begin
                        if (cfg_data == '0)
                        begin
                            default_reg <= CFG_DATA_W'(1);
                        end
                        else if (cfg_data > DEFAULT_SIZE_MAX)
                        begin
                            default_reg <= DEFAULT_SIZE_MAX;
                        end
                        else
                        begin
                            default_reg <= cfg_data;
                        end
                    end
                    REG_ARENA_ALIGN_LOG2:
                    begin
                        if (cfg_data[ALIGN_W-1:0] > ALIGN_LOG2_MAX)
                        begin
                            arena_reg <= ALIGN_LOG2_MAX;
                        end
                        else
                        begin
                            arena_reg <= cfg_data[ALIGN_W-1:0];
                        end
                    end
                    default:
                    begin
                        arena_reg <= arena_reg;
                    end
                endcase
            end
            if (cmd.load)
            begin
                second_reg <= 1'b0;
            end
            if (cmd.advance)
            begin
                second_reg <= 1'b1;
            end
            if (cmd.alloc_commit)
            begin
                active_reg      <= tgt_reg;
                active_fill_reg <= PAGE_W'(sum);
            end
            if (cmd.alloc_open)
            begin
                open_reg        <= open_reg + CNT_W'(1);
                active_reg      <= new_idx;
                active_fill_reg <= PAGE_W'(size_reg);
            end
            if (cmd.arena_clear)
            begin
                active_reg      <= '0;
                active_fill_reg <= '0;
            end
            if (cmd.roll_commit)
            begin
                active_reg      <= mpage_idx;
                active_fill_reg <= PAGE_W'(moff_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg     <= in_action;
            size_reg       <= in_size;
            alg_reg        <= in_align;
            mpage_reg      <= in_mpage;
            moff_reg       <= in_moff;
            status_reg     <= ST_OK;
            grant_page_reg <= '0;
            grant_off_reg  <= '0;
            tgt_reg        <= active_reg;
            start_reg      <= align_up(AW'(active_fill_reg), in_align);
            base_reg       <= active_fill_reg;
        end
        if (cmd.advance)
        begin
            // pages above the active one are always empty: start at zero
            tgt_reg   <= next_idx;
            start_reg <= '0;
            base_reg  <= '0;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status_code;
        end
        if (cmd.alloc_commit)
        begin
            grant_page_reg <= tgt_reg;
            grant_off_reg  <= PAGE_W'(start_reg);
        end
        if (cmd.alloc_open)
        begin
            grant_page_reg <= new_idx;
            grant_off_reg  <= '0;
        end
        if (cmd.arena_clear)
        begin
            walk_reg <= '0;
        end
        if (cmd.roll_commit)
        begin
            walk_reg <= CNT_W'(mpage_w) + CNT_W'(1);
        end
        if (cmd.clear_write || cmd.walk_clear)
        begin
            walk_reg <= walk_reg + CNT_W'(1);
        end
    end

    assign st.action          = action_reg;
    assign st.zero_size       = (size_reg == '0);
    assign st.align_bad       = (alg_reg > arena_reg);
    assign st.fit             = fit;
    assign st.second          = second_reg;
    assign st.next_exists     = (CNT_W'(active_reg) + CNT_W'(1)) < open_reg;
    assign st.table_full      = open_reg >= CNT_W'(MAX_PAGES);
    assign st.marker_in_range = mpage_w < MW'(open_reg);
    assign st.marker_fits     = PAGE_W'(moff_reg) <= fill_rd_reg;
    assign st.walk_more       = walk_reg < open_reg;

    assign res.status                = status_reg;
    assign res.alloc_page            = PAGE_OUT_W'(grant_page_reg);
    assign res.alloc_offset          = OFFSET_W'(grant_off_reg);
    assign res.current_marker_page   = PAGE_OUT_W'(active_reg);
    assign res.current_marker_offset = OFFSET_W'(active_fill_reg);
    assign res.used_total            = used_reg;
    assign res.peak_total            = peak_tot_reg;
    assign res.capacity_total        = cap_tot_reg;
    assign res.pages_open            = COUNT_OUT_W'(open_reg);

    a_active_below_open: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(active_reg) < open_reg)
        else $error("active page outside the opened pages");

    a_open_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg != '0 && open_reg <= CNT_W'(MAX_PAGES))
        else $error("open page count out of range");

    a_commit_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_commit |-> fit)
        else $error("allocation committed to a page it does not fit");

endmodule

>>> hdl/paged_bump_allocator_unit.sv
// Top level of the paged bump allocator: control, page table and result register.
//
// Each request transfer carries one command: allocate, reset the arena, roll back
// to a marker, or query; each produces exactly one result transfer holding the
// status, the granted page and offset (zero unless an allocation succeeds), the
// current marker and the used, peak and capacity totals. Items are handled one at
// a time by a state machine over a page table with a single registered read port,
// so the work per item follows the page-table accesses: an allocation reads the
// active page and, if it does not fit, the next opened page; an arena reset
// clears every opened page, and a rollback reads and clears each opened page
// above the marker page. A new request is taken as soon as the block is back in
// idle, while the previous result may still sit in the output register; the block
// only stalls if that register is still full when the next result is ready. After
// reset the block first seeds page 0, during which no request is taken.
// Configuration writes take effect for pages opened afterwards and must be
// issued only while the block is idle.
module paged_bump_allocator_unit
    import pba_pkg::*;
#(
    parameter int MAX_PAGES = 16,
    parameter int SIZE_BITS = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // request_size, request_align_log2, marker_page, marker_offset, zero pad
    input  logic [((SIZE_BITS + 29 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // action
    input  logic [ACTION_W-1:0]   s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // alloc_page, alloc_offset, current_marker_page, current_marker_offset,
    // used_total, peak_total, capacity_total, pages_open, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [STATUS_W-1:0]   m_axis_tuser
);

    pba_cmd_t    cmd;
    pba_status_t st;
    pba_result_t res;
    pba_result_t out_reg;
    logic        m_tvalid_reg;
    logic        out_free;
    logic        result_load;

    // The output slot is free if empty or being drained in this cycle
    assign out_free = !m_tvalid_reg || m_axis_tready;

    pba_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .out_free    (out_free),
        .st          (st),
        .cmd         (cmd),
        .result_load (result_load)
    );

    pba_datapath #(
        .MAX_PAGES (MAX_PAGES),
        .SIZE_BITS (SIZE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_action (s_axis_tuser),
        .in_size   (s_axis_tdata[SIZE_BITS-1:0]),
        .in_align  (s_axis_tdata[SIZE_BITS+3:SIZE_BITS]),
        .in_mpage  (s_axis_tdata[SIZE_BITS+7:SIZE_BITS+4]),
        .in_moff   (s_axis_tdata[SIZE_BITS+28:SIZE_BITS+8]),
        .cmd       (cmd),
        .st        (st),
        .res       (res)
    );

    // Hold the finished result until the downstream side takes the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {
        {(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
        out_reg.pages_open,
        out_reg.capacity_total,
        out_reg.peak_total,
        out_reg.used_total,
        out_reg.current_marker_offset,
        out_reg.current_marker_page,
        out_reg.alloc_offset,
        out_reg.alloc_page
    };

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |-> (!m_tvalid_reg || m_axis_tready))
        else $error("result register loaded while a result still waits");

    a_one_item_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request taken before the first was finished");

endmodule

>>> dv/testbench.sv
// Self-checking testbench of the paged bump allocator: directed and random request streams.
module testbench;
    import pba_pkg::*;

    localparam int PAGES       = 16;
    localparam int SZ_BITS     = 20;
    localparam int REQ_TDATA_W = ((SZ_BITS + 29 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 200;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 240;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // request_size, request_align_log2, marker_page, marker_offset, zero pad
    logic [REQ_TDATA_W-1:0] s_axis_tdata;
    // action
    logic [ACTION_W-1:0]    s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // alloc_page, alloc_offset, current_marker_page, current_marker_offset,
    // used_total, peak_total, capacity_total, pages_open, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // status
    logic [STATUS_W-1:0]    m_axis_tuser;

    bit          burst_mode;
    bit          hold_off_req;
    int unsigned cycles;

    // Shadow copy of the page table; predicts one result per request transfer
    // and holds the results still owed by the block.
    class arena_tracker;
        logic [OFFSET_W-1:0]   page_cap  [PAGES];
        logic [OFFSET_W-1:0]   page_used [PAGES];
        logic [OFFSET_W-1:0]   page_high [PAGES];
        int unsigned           opened;
        int unsigned           active;
        logic [CFG_DATA_W-1:0] dflt_size;
        logic [ALIGN_W-1:0]    arena_lg;
        pba_result_t           pending_results[$];
        int unsigned           mismatches;

        function new();
            dflt_size = DEFAULT_SIZE_RESET;
            arena_lg  = ALIGN_LOG2_RESET;
            for (int i = 0; i < PAGES; i++)
            begin
                page_cap[i]  = '0;
                page_used[i] = '0;
                page_high[i] = '0;
            end
            page_cap[0] = OFFSET_W'(round_up(dflt_size, arena_lg));
            opened      = 1;
            active      = 0;
            mismatches  = 0;
        endfunction

        function int unsigned round_up(int unsigned x, int unsigned lg);
            int unsigned m;
            m = (1 << lg) - 1;
            return (x + m) & ~m;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == REG_DEFAULT_PAGE_SIZE)
            begin
                if (value == '0)
                    dflt_size = 1;
                else if (value > DEFAULT_SIZE_MAX)
                    dflt_size = DEFAULT_SIZE_MAX;
                else
                    dflt_size = value;
            end
            else
            begin
                arena_lg = value[ALIGN_W-1:0];
                if (arena_lg > ALIGN_LOG2_MAX)
                    arena_lg = ALIGN_LOG2_MAX;
            end
        endfunction

        function void accept_request(logic [ACTION_W-1:0] act, logic [REQ_TDATA_W-1:0] data);
            int unsigned size, alg, mpage, moff;
            int unsigned p, start, need, base;
            int unsigned used, high, capsum;
            bit          placed;
            pba_result_t r;
            size  = data[SZ_BITS-1:0];
            alg   = data[SZ_BITS+3:SZ_BITS];
            mpage = data[SZ_BITS+7:SZ_BITS+4];
            moff  = data[SZ_BITS+28:SZ_BITS+8];
            r     = '0;
            r.status = ST_OK;
            case (act)
                ACT_ALLOC:
                begin
                    // zero size is checked ahead of the alignment limit
                    if (size == 0)
                        r.status = ST_ZERO;
                    else if (alg > arena_lg)
                        r.status = ST_ALIGN;
                    else
                    begin
                        placed = 1'b1;
                        p      = active;
                        start  = round_up(page_used[p], alg);
                        if (start + size > page_cap[p])
                        begin
                            if (active + 1 < opened)
                            begin
                                // next page exists: try it once, never skip further
                                p     = active + 1;
                                start = round_up(page_used[p], alg);
                                if (start + size > page_cap[p])
                                    placed = 1'b0;
                            end
                            else if (opened >= PAGES)
                                placed = 1'b0;
                            else
                            begin
                                need = size + (1 << alg);
                                base = round_up(dflt_size, arena_lg);
                                p    = opened;
                                page_cap[p]  = OFFSET_W'(round_up((need > base) ? need : base,
                                                                  arena_lg));
                                page_used[p] = '0;
                                page_high[p] = '0;
                                opened++;
                                start = 0;
                            end
                        end
                        if (placed)
                        begin
                            active       = p;
                            page_used[p] = OFFSET_W'(start + size);
                            if (page_used[p] > page_high[p])
                                page_high[p] = page_used[p];
                            r.alloc_page   = PAGE_OUT_W'(p);
                            r.alloc_offset = OFFSET_W'(start);
                        end
                        else
                            r.status = ST_SPACE;
                    end
                end
                ACT_RESET:
                begin
                    for (int i = 0; i < opened; i++)
                        page_used[i] = '0;
                    active = 0;
                end
                ACT_ROLL:
                begin
                    if (mpage >= opened || moff > page_used[mpage])
                        r.status = ST_MARKER;
                    else
                    begin
                        for (int i = mpage + 1; i < opened; i++)
                            page_used[i] = '0;
                        page_used[mpage] = OFFSET_W'(moff);
                        active           = mpage;
                    end
                end
                default:
                begin
                end
            endcase
            used   = 0;
            high   = 0;
            capsum = 0;
            for (int i = 0; i < opened; i++)
            begin
                used   += page_used[i];
                high   += page_high[i];
                capsum += page_cap[i];
            end
            r.current_marker_page   = PAGE_OUT_W'(active);
            r.current_marker_offset = page_used[active];
            r.used_total            = TOT_W'(used);
            r.peak_total            = TOT_W'(high);
            r.capacity_total        = TOT_W'(capsum);
            r.pages_open            = COUNT_OUT_W'(opened);
            pending_results = {pending_results, r};
        endfunction

        function void check_field(string name, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void match_result(logic [STATUS_W-1:0] st, logic [OUT_TDATA_W-1:0] d);
            pba_result_t e;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result transfer with none owed, expected none actual %0h",
                             $time, st);
                return;
            end
            e = pending_results.pop_front();
            check_field("status", e.status, st);
            check_field("alloc_page", e.alloc_page, d[3:0]);
            check_field("alloc_offset", e.alloc_offset, d[24:4]);
            check_field("current_marker_page", e.current_marker_page, d[28:25]);
            check_field("current_marker_offset", e.current_marker_offset, d[49:29]);
            check_field("used_total", e.used_total, d[74:50]);
            check_field("peak_total", e.peak_total, d[99:75]);
            check_field("capacity_total", e.capacity_total, d[124:100]);
            check_field("pages_open", e.pages_open, d[129:125]);
        endfunction
    endclass

    arena_tracker tracker;

    paged_bump_allocator_unit #(
        .MAX_PAGES (PAGES),
        .SIZE_BITS (SZ_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Gap length for either side: mostly none or short, now and then long;
    // none at all while a burst phase runs.
    function automatic int unsigned idle_length();
        int unsigned r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic [REQ_TDATA_W-1:0] pack_request(int unsigned size, int unsigned alg,
                                                            int unsigned mpage, int unsigned moff);
        logic [REQ_TDATA_W-1:0] d;
        d = '0;
        d[SZ_BITS-1:0]          = size[SZ_BITS-1:0];
        d[SZ_BITS+3:SZ_BITS]    = alg[3:0];
        d[SZ_BITS+7:SZ_BITS+4]  = mpage[3:0];
        d[SZ_BITS+28:SZ_BITS+8] = moff[20:0];
        return d;
    endfunction

    // Offer one request, hold it until the transfer, note it for prediction,
    // then drop valid for a random gap if one is drawn.
    task automatic send_request(input logic [ACTION_W-1:0] act, input int unsigned size,
                                input int unsigned alg, input int unsigned mpage,
                                input int unsigned moff);
        logic [REQ_TDATA_W-1:0] payload;
        int unsigned            gap;
        payload = pack_request(size, alg, mpage, moff);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= payload;
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.accept_request(act, payload);
        gap = idle_length();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering, let every owed result arrive, then write both registers.
    task automatic program_arena(input logic [CFG_DATA_W-1:0] dflt, input logic [3:0] lg);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEFAULT_PAGE_SIZE;
        cfg_data  <= dflt;
        @(posedge clk);
        tracker.write_reg(REG_DEFAULT_PAGE_SIZE, dflt);
        // upper data bits carry noise; only the low nibble counts for alignment
        cfg_index <= REG_ARENA_ALIGN_LOG2;
        cfg_data  <= {17'($urandom), lg};
        @(posedge clk);
        tracker.write_reg(REG_ARENA_ALIGN_LOG2, {17'd0, lg});
        cfg_we <= 1'b0;
    endtask

    // Walk through the corner cases under the reset configuration
    // (page 0 holds 4096 bytes, arena alignment 16).
    task automatic run_directed();
        send_request(ACT_QUERY, 0, 0, 0, 0);
        // zero size wins over an oversized alignment
        send_request(ACT_ALLOC, 0, 15, 0, 0);
        send_request(ACT_ALLOC, 16, 5, 0, 0);
        send_request(ACT_ALLOC, 1, 0, 0, 0);
        // does not fit page 0: open page 1 sized by size plus alignment
        send_request(ACT_ALLOC, 4096, 4, 0, 0);
        send_request(ACT_ALLOC, 1048575, 4, 0, 0);
        send_request(ACT_QUERY, 0, 0, 0, 0);
        // bad markers: unopened page, offset beyond the fill
        send_request(ACT_ROLL, 0, 0, 15, 0);
        send_request(ACT_ROLL, 0, 0, 0, 2);
        send_request(ACT_ROLL, 0, 0, 0, 1);
        send_request(ACT_ALLOC, 4000, 4, 0, 0);
        // spills into the already opened next page
        send_request(ACT_ALLOC, 200, 3, 0, 0);
        send_request(ACT_ROLL, 0, 0, 0, 0);
        send_request(ACT_ALLOC, 4096, 0, 0, 0);
        // next opened page too small: no space, active page stays
        send_request(ACT_ALLOC, 4113, 0, 0, 0);
        send_request(ACT_ALLOC, 4112, 0, 0, 0);
        // arena reset keeps the peaks
        send_request(ACT_RESET, 0, 0, 0, 0);
        send_request(ACT_QUERY, 0, 0, 0, 0);
        send_request(ACT_ALLOC, 1, 4, 0, 0);
        send_request(ACT_ROLL, 0, 0, 2, 0);
        send_request(ACT_ALLOC, 1048575, 0, 15, 2097151);
        send_request(ACT_ALLOC, 1048575, 4, 15, 2097151);
        // marker exactly at the fill is still valid
        send_request(ACT_ROLL, 1048575, 15, 3, 1048575);
        send_request(ACT_ROLL, 0, 0, 0, 2097151);
    endtask

    // One random request: mostly allocations and well-formed rollbacks built
    // from the shadow table, the rest resets, queries and broken markers.
    task automatic issue_random();
        int unsigned         r, s, d, size, alg, mpage, moff, f;
        logic [ACTION_W-1:0] act;
        d     = tracker.round_up(tracker.dflt_size, tracker.arena_lg);
        r     = $urandom_range(0, 99);
        size  = $urandom_range(0, 1048575);
        alg   = $urandom_range(0, 15);
        mpage = $urandom_range(0, 15);
        moff  = $urandom_range(0, 2097151);
        if (r < 60)
        begin
            act = ACT_ALLOC;
            s   = $urandom_range(0, 99);
            if (s < 4)
                size = 0;
            else if (s < 55)
                size = $urandom_range(1, (d < 1024) ? d : 1024);
            else if (s < 85)
                size = $urandom_range(1, (d < 1048575) ? d : 1048575);
            else if (s < 96)
                size = $urandom_range(1, (2 * d < 1048575) ? 2 * d : 1048575);
            s = $urandom_range(0, 99);
            if (s < 75)
                alg = $urandom_range(0, tracker.arena_lg);
            else if (s < 88)
                alg = tracker.arena_lg;
        end
        else if (r < 80)
        begin
            act   = ACT_ROLL;
            mpage = $urandom_range(0, tracker.opened - 1);
            f     = tracker.page_used[mpage];
            s     = $urandom_range(0, 99);
            if (s < 30)
                moff = f;
            else if (s < 50)
                moff = 0;
            else
                moff = $urandom_range(0, f);
        end
        else if (r < 86)
        begin
            // broken marker: random noise, just past the fill, or first unopened page
            act = ACT_ROLL;
            s   = $urandom_range(0, 2);
            if (s == 1)
            begin
                mpage = $urandom_range(0, tracker.opened - 1);
                moff  = tracker.page_used[mpage] + $urandom_range(1, 64);
            end
            else if (s == 2 && tracker.opened < PAGES)
            begin
                mpage = tracker.opened;
                moff  = 0;
            end
        end
        else if (r < 93)
            act = ACT_RESET;
        else
            act = ACT_QUERY;
        send_request(act, size, alg, mpage, moff);
    endtask

    // Result side: check each transfer, stall at random, and serve the long
    // hold-off once so that the block backs up and stalls its input.
    initial
    begin : result_sink
        int unsigned stall;
        stall = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                tracker.match_result(m_axis_tuser, m_axis_tdata);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall        = HOLD_CYCLES;
            end
            else if (stall == 0)
                stall = idle_length();
            if (stall > 0)
            begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycles);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] dflt;
        logic [3:0]            lg;
        tracker       = new();
        burst_mode    = 1'b0;
        hold_off_req  = 1'b0;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        // leave room for the seeding of page 0
        repeat (4) @(posedge clk);
        run_directed();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    dflt = DEFAULT_SIZE_MAX;
                    lg   = 4'd12;
                end
                1:
                begin
                    // both values beyond their limits: clamp to the maxima
                    dflt = 21'h1FFFFF;
                    lg   = 4'd15;
                end
                2:
                begin
                    dflt = 21'd3000;
                    lg   = 4'd5;
                end
                3:
                begin
                    // zero default acts as one byte
                    dflt = '0;
                    lg   = 4'd0;
                end
                4:
                begin
                    dflt = 21'd1;
                    lg   = 4'd13;
                end
                5:
                begin
                    dflt = CFG_DATA_W'($urandom_range(0, 2097151));
                    lg   = 4'($urandom_range(0, 15));
                end
                default:
                begin
                    dflt = CFG_DATA_W'($urandom_range(1, 512));
                    lg   = 4'($urandom_range(0, 6));
                end
            endcase
            program_arena(dflt, lg);
            burst_mode = (ph == 1 || ph == 4);
            if (ph == 2)
                hold_off_req = 1'b1;
            repeat (PHASE_ITEMS) issue_random();
        end

        s_axis_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        // hold a little longer to catch any stray result transfer
        repeat (60) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> paged_bump_allocator_unit.f
hdl/pba_pkg.sv
hdl/pba_ctrl.sv
hdl/pba_datapath.sv
hdl/paged_bump_allocator_unit.sv
dv/testbench.sv
